@@ sv/dzpw_pkg.sv @@
`default_nettype none
package dzpw_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned SqW    = 50;
  localparam int unsigned RootW  = 25;
  localparam int unsigned CordW  = 44;
  localparam int unsigned ZW     = 24;
  localparam int unsigned ThW    = 17;
  localparam int unsigned TabLen = 24;
  localparam logic signed [ThW-1:0] HalfPiQ12 = 17'sd6434;
  localparam logic signed [PosW-1:0] OutMax = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] OutMin = 24'sh800000;

  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_DIST_DZ    = 3'd2,
    REG_HEAD_DZ    = 3'd3,
    REG_DIST_GAIN  = 3'd4,
    REG_TURN_GAIN  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] target_x;
    logic signed [PosW-1:0] target_y;
    logic [22:0]            distance_deadzone;
    logic [14:0]            heading_deadzone;
    logic [15:0]            distance_gain;
    logic [15:0]            turning_gain;
  } cfg_t;

  function automatic logic [ZW-1:0] atan_entry(input int unsigned i);
    logic [ZW-1:0] v;
    v = '0;
    unique case (i)
      0: v = 24'd823550;
      1: v = 24'd486171;
      2: v = 24'd256879;
      3: v = 24'd130396;
      4: v = 24'd65451;
      5: v = 24'd32757;
      6: v = 24'd16383;
      7: v = 24'd8192;
      8: v = 24'd4096;
      9: v = 24'd2048;
      10: v = 24'd1024;
      11: v = 24'd512;
      12: v = 24'd256;
      13: v = 24'd128;
      14: v = 24'd64;
      15: v = 24'd32;
      16: v = 24'd16;
      17: v = 24'd8;
      18: v = 24'd4;
      19: v = 24'd2;
      20: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [PosW-1:0] sat24(input logic signed [PosW+1:0] v);
    logic signed [PosW-1:0] r;
    r = v[PosW-1:0];
    if (v > $signed({{2{OutMax[PosW-1]}}, OutMax})) r = OutMax;
    else if (v < $signed({{2{OutMin[PosW-1]}}, OutMin})) r = OutMin;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/dzpw_heading.sv @@
`default_nettype none
module dzpw_heading #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic signed [dzpw_pkg::PosW-1:0] target_x_i,
  input  wire logic signed [dzpw_pkg::PosW-1:0] target_y_i,
  output logic signed [dzpw_pkg::ThW-1:0]      th_o
);
  import dzpw_pkg::*;

  logic signed [CordW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CordW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW+1:0]    z_q [CORDIC_STEPS+1];
  logic                    zero_q;
  logic signed [ThW-1:0]   axis_q;
  logic signed [ZW+1:0]    zr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else begin
      zero_q <= (target_y_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= (target_x_i > 0) ? -HalfPiQ12 : ((target_x_i < 0) ? HalfPiQ12 : '0);
    if (target_y_i < 0) begin
      x_q[0] <= $signed({-{{(CordW-PosW-16){target_y_i[PosW-1]}}, target_y_i}, 16'd0}) ;
      y_q[0] <= $signed({-{{(CordW-PosW-16){target_x_i[PosW-1]}}, target_x_i}, 16'd0}) ;
    end else begin
      x_q[0] <= $signed({{(CordW-PosW-16){target_y_i[PosW-1]}}, target_y_i, 16'd0});
      y_q[0] <= $signed({{(CordW-PosW-16){target_x_i[PosW-1]}}, target_x_i, 16'd0});
    end
    z_q[0] <= '0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic [ZW+1:0] a;
    assign a = {2'b00, ((i < TabLen) ? atan_entry(i) : '0)};
    always_ff @(posedge clk_i) begin
      if (y_q[i] < 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - $signed(a);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + $signed(a);
      end
    end
  end

  assign zr = (z_q[CORDIC_STEPS] + 26'sd128) >>> 8;
  assign th_o = zero_q ? axis_q : -zr[ThW-1:0];
endmodule
`default_nettype wire

@@ sv/dzpw_isqrt.sv @@
`default_nettype none
module dzpw_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [dzpw_pkg::SqW-1:0]    sq_i,
  output logic [dzpw_pkg::RootW-1:0]       root_o
);
  import dzpw_pkg::*;

  localparam int unsigned Steps = RootW;

  logic [SqW-1:0]   rem_q  [Steps+1];
  logic [RootW-1:0] root_q [Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= sq_i;
      root_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_bit
    localparam int unsigned B = Steps - 1 - i;
    logic [SqW+1:0] trial;
    assign trial = ({27'd0, root_q[i]} << (B + 1)) + ({{(SqW+1){1'b0}}, 1'b1} << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({2'b00, rem_q[i]} >= trial) begin
          rem_q[i+1]  <= rem_q[i] - trial[SqW-1:0];
          root_q[i+1] <= root_q[i] | (RootW'(1) << B);
        end else begin
          rem_q[i+1]  <= rem_q[i];
          root_q[i+1] <= root_q[i];
        end
      end
    end
  end

  assign root_o = root_q[Steps];
endmodule
`default_nettype wire

@@ sv/deadzone_pose_to_wheel_speed_top.sv @@
`default_nettype none
// Channel  | Direction | Signals
// pose     | in        | pose_valid_i, pose_stall_o, pose_x_i, pose_y_i, pose_heading_i
// drive    | out       | drive_valid_o, drive_stall_i, right_drive_o, left_drive_o
// config   | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// One pose per cycle while drive is not stalled; a result leaves after, in order:
// three front stages, the 26-stage root pipeline, then compare, multiply, saturate.
// Target heading runs on its own CORDIC_STEPS + 1 stages from the registers.
// Reset clears valid bits and loads register defaults; write config only when empty.
// A stall on drive freezes the whole pose pipeline (the heading pipeline keeps running), which holds every transaction.
module deadzone_pose_to_wheel_speed_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            pose_valid_i,
  output logic                                 pose_stall_o,
  input  wire logic signed [dzpw_pkg::PosW-1:0]  pose_x_i,
  input  wire logic signed [dzpw_pkg::PosW-1:0]  pose_y_i,
  input  wire logic signed [dzpw_pkg::HeadW-1:0] pose_heading_i,
  output logic                                 drive_valid_o,
  input  wire logic                            drive_stall_i,
  output logic signed [dzpw_pkg::PosW-1:0]       right_drive_o,
  output logic signed [dzpw_pkg::PosW-1:0]       left_drive_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [2:0]                      cfg_index_i,
  input  wire logic [23:0]                     cfg_data_i
);
  import dzpw_pkg::*;

  localparam int unsigned Lat = RootW + 4;

  cfg_t cfg_q;
  logic signed [ThW-1:0] th_w;
  logic running;

  assign cfg_ready_o = 1'b1;
  assign running = !drive_stall_i;
  assign pose_stall_o = drive_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x          <= 24'sd12800;
      cfg_q.target_y          <= 24'sd12800;
      cfg_q.distance_deadzone <= 23'd1792;
      cfg_q.heading_deadzone  <= 15'd205;
      cfg_q.distance_gain     <= 16'd13107;
      cfg_q.turning_gain      <= 16'd6554;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TARGET_X:  cfg_q.target_x <= cfg_data_i;
        REG_TARGET_Y:  cfg_q.target_y <= cfg_data_i;
        REG_DIST_DZ:   cfg_q.distance_deadzone <= cfg_data_i[22:0];
        REG_HEAD_DZ:   cfg_q.heading_deadzone <= cfg_data_i[14:0];
        REG_DIST_GAIN: cfg_q.distance_gain <= cfg_data_i[15:0];
        REG_TURN_GAIN: cfg_q.turning_gain <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  dzpw_heading #(.CORDIC_STEPS(CORDIC_STEPS)) u_heading (
    .clk_i, .rst_ni,
    .target_x_i(cfg_q.target_x), .target_y_i(cfg_q.target_y), .th_o(th_w)
  );

  // stage 1: differences
  logic v1_q, neg1_q;
  logic [DiffW-1:0] adx1_q, ady1_q;
  logic signed [HeadW-1:0] ph1_q;
  logic signed [DiffW-1:0] dx_w, dy_w;
  assign dx_w = DiffW'(cfg_q.target_x) - DiffW'(pose_x_i);
  assign dy_w = DiffW'(cfg_q.target_y) - DiffW'(pose_y_i);

  // stage 2: squares
  logic v2_q, neg2_q;
  logic [SqW-1:0] xx2_q, yy2_q;
  logic signed [HeadW-1:0] ph2_q;

  // stage 3: sum into root pipe
  logic v3_q, neg3_q;
  logic [SqW-1:0] sq3_q;
  logic signed [HeadW-1:0] ph3_q;

  logic [RootW-1:0] root_w;
  logic [Lat-1:0] vline_q;
  logic [RootW:0] negline_q;
  logic signed [HeadW-1:0] phline_q [RootW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; vline_q <= '0;
    end else if (running) begin
      v1_q <= pose_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vline_q <= {vline_q[Lat-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (running) begin
      adx1_q <= dx_w[DiffW-1] ? DiffW'(-dx_w) : dx_w;
      ady1_q <= dy_w[DiffW-1] ? DiffW'(-dy_w) : dy_w;
      neg1_q <= dx_w[DiffW-1] & dy_w[DiffW-1];
      ph1_q  <= pose_heading_i;
      xx2_q  <= SqW'(adx1_q) * SqW'(adx1_q);
      yy2_q  <= SqW'(ady1_q) * SqW'(ady1_q);
      neg2_q <= neg1_q; ph2_q <= ph1_q;
      sq3_q  <= xx2_q + yy2_q;
      neg3_q <= neg2_q; ph3_q <= ph2_q;
      negline_q <= {negline_q[RootW-1:0], neg3_q};
      phline_q[0] <= ph3_q;
      for (int k = 0; k < RootW; k++) phline_q[k+1] <= phline_q[k];
    end
  end

  dzpw_isqrt u_isqrt (.clk_i(clk_i), .en_i(running), .sq_i(sq3_q), .root_o(root_w));

  // root stage: heading error and compares
  logic signed [ThW:0] dth4_q;
  logic turn4_q, neg4_q;
  logic [RootW-1:0] d4_q;
  logic signed [ThW:0] dth_w;
  logic [ThW:0] adth_w;
  assign dth_w = (ThW+1)'(th_w) - (ThW+1)'(phline_q[RootW]);
  assign adth_w = dth_w[ThW] ? (ThW+1)'(-dth_w) : dth_w;

  // multiply stage
  logic signed [ThW+17:0] c2m5_q;
  logic [RootW+16:0] c1m5_q;
  logic turn5_q, neg5_q;

  logic signed [PosW+1:0] c1_w, c2_w;
  logic signed [ThW+17:0] c2r_w;
  logic [RootW+16:0] c1r_w;
  assign c2r_w = (c2m5_q + (ThW+18)'(1 << 19)) >>> 20;
  assign c1r_w = (c1m5_q + (RootW+17)'(1 << 15)) >> 16;
  assign c2_w = turn5_q ? (PosW+2)'(c2r_w) : '0;
  assign c1_w = turn5_q ? '0 : (neg5_q ? -$signed({1'b0, c1r_w[PosW:0]}) :
                                        $signed({1'b0, c1r_w[PosW:0]}));

  logic signed [PosW-1:0] r_q, l_q;

  always_ff @(posedge clk_i) begin
    if (running) begin
      dth4_q  <= dth_w;
      turn4_q <= adth_w > (ThW+1)'(cfg_q.heading_deadzone);
      neg4_q  <= negline_q[RootW];
      d4_q    <= (root_w <= RootW'(cfg_q.distance_deadzone)) ? '0 : root_w;
      c2m5_q  <= $signed({1'b0, cfg_q.turning_gain}) * dth4_q;
      c1m5_q  <= (RootW+17)'(cfg_q.distance_gain) * (RootW+17)'(d4_q);
      turn5_q <= turn4_q; neg5_q <= neg4_q;
      r_q <= sat24(c1_w + c2_w);
      l_q <= sat24(c1_w - c2_w);
    end
  end

  assign drive_valid_o = vline_q[Lat-1];
  assign right_drive_o = r_q;
  assign left_drive_o  = l_q;
endmodule
`default_nettype wire
